[src/sust_pkg.sv]
package sust_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int LIM_W    = 5;
  localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam logic [LIM_W-1:0] CAP_RESET = LIM_W'(16);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_ALREADY     = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd3;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [DATA_W-1:0] key;
  } cell_cmd_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

[src/sust_cell.sv]
module sust_cell (
  input  logic                              clk,
  input  logic                              ent_valid,
  input  sust_pkg::cell_cmd_t               cmd,
  input  logic                              lt_prev,
  input  logic signed [sust_pkg::DATA_W-1:0] prev_value,
  input  logic signed [sust_pkg::DATA_W-1:0] next_value,
  output logic signed [sust_pkg::DATA_W-1:0] value,
  output sust_pkg::cell_flag_t              flag
);
  import sust_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // Entries below the key keep; on insert the key goes to the next one.
  always_comb begin
    flag.lt = ent_valid && (value_r < cmd.key);
    flag.eq = ent_valid && (value_r == cmd.key);
    value_nxt = value_r;
    if (cmd.ins && !flag.lt) begin
      value_nxt = lt_prev ? cmd.key : prev_value;
    end else if (cmd.del && !flag.lt) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

[src/sorted_unique_set_table_core.sv]
// Stages: a request beat is held in the request stage and its result beat in
//   the result stage; a stalled result beat holds the request stage.
// Throughput: one request per cycle while results are not stalled; every cell
//   compares and shifts at once, so back-to-back requests see the set as left by the one before.
// Reset (rst_n low, synchronous): the set empties, capacity_limit returns to
//   16, both channels drain. Cell contents are not cleared.
module sorted_unique_set_table_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic signed [sust_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_found,
  output logic [sust_pkg::POS_W-1:0]         out_position,
  output logic [sust_pkg::POS_W-1:0]         out_set_count,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import sust_pkg::*;

  // Configuration register
  logic [LIM_W-1:0] cap_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  // Only word 0 exists; byte lanes within the word are ignored.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(cap_r) : 32'd0;

  // Request stage
  logic                     req_v_r;
  logic [1:0]               req_func_r;
  logic signed [DATA_W-1:0] req_key_r;
  logic                     exec;
  logic                     in_acc;

  // Execute when the result register is free or being drained this cycle.
  assign exec     = req_v_r && (!out_valid || !out_stall);
  assign in_stall = req_v_r && !exec;
  assign in_acc   = in_valid && !in_stall;

  // Entry count and cell row
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  cell_cmd_t                cmd;
  cell_flag_t               flag  [CAPACITY];
  logic signed [DATA_W-1:0] cval  [CAPACITY];
  logic [CAPACITY-1:0]      lt_vec;
  logic [CAPACITY-1:0]      eq_vec;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     lt_prev;
    logic signed [DATA_W-1:0] prev_v;
    logic signed [DATA_W-1:0] next_v;

    // The first cell sits at the insertion point whenever it is not below the key.
    if (g == 0) begin : g_first
      assign lt_prev = 1'b1;
      assign prev_v  = req_key_r;
    end else begin : g_mid
      assign lt_prev = flag[g-1].lt;
      assign prev_v  = cval[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = cval[g];
    end else begin : g_inner
      assign next_v = cval[g+1];
    end

    sust_cell u_cell (
      .clk        (clk),
      .ent_valid  (CNT_W'(g) < count_r),
      .cmd        (cmd),
      .lt_prev    (lt_prev),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cval[g]),
      .flag       (flag[g])
    );

    assign lt_vec[g] = flag[g].lt;
    assign eq_vec[g] = flag[g].eq;
  end

  // Lower bound: entries below the key form a run from index 0, so the
  // position is the first cell that is not below the key.
  logic [CNT_W-1:0] lb_pos;
  logic             present;
  logic             full;

  always_comb begin
    lb_pos = CNT_W'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt_vec[i]) begin
        lb_pos = CNT_W'(i);
      end
    end
  end

  assign present = |eq_vec;
  assign full    = (CMP_W'(count_r) >= CMP_W'(cap_r)) ||
                   (CMP_W'(count_r) >= CMP_W'(CAPACITY));

  // Decode the request, drive the cells and build the result.
  logic [1:0]       status_c;
  logic [CNT_W-1:0] pos_c;

  always_comb begin
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.key   = req_key_r;
    count_nxt = count_r;
    status_c  = ST_DONE;
    pos_c     = present ? lb_pos : count_r;
    unique case (req_func_r)
      FUNC_INSERT: begin
        if (full) begin
          status_c = ST_FULL;
        end else if (present) begin
          status_c = ST_ALREADY;
        end else begin
          cmd.ins   = exec;
          pos_c     = lb_pos;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_DELETE: begin
        if (present) begin
          cmd.del   = exec;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_c = ST_NOT_PRESENT;
        end
      end
      default: begin
        // lookup, and the unused code acts as one
        if (!present) begin
          status_c = ST_NOT_PRESENT;
        end
      end
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      req_v_r   <= 1'b0;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_r <= pwdata[LIM_W-1:0];
      end
      // Hold the request until it executes; refill on accept.
      if (in_acc) begin
        req_v_r <= 1'b1;
      end else if (exec) begin
        req_v_r <= 1'b0;
      end
      if (exec) begin
        count_r   <= count_nxt;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_func_r <= in_func;
      req_key_r  <= in_value;
    end
    if (exec) begin
      out_status    <= status_c;
      out_found     <= present;
      out_position  <= POS_W'(pos_c);
      out_set_count <= POS_W'(count_nxt);
    end
  end

endmodule

[src/sust_chk.sv]
module sust_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         in_func,
  input logic signed [sust_pkg::DATA_W-1:0] in_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [1:0]                         out_status,
  input logic                               out_found,
  input logic [sust_pkg::POS_W-1:0]         out_position,
  input logic [sust_pkg::POS_W-1:0]         out_set_count
);
  import sust_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found) &&
      $stable(out_position) && $stable(out_set_count))
    else $error("stalled result beat changed");

  // Hold a stalled request beat.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_value))
    else $error("stalled request beat changed");

  a_already_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ALREADY) |->
      out_found && (out_position < out_set_count))
    else $error("already-present status without found or with position beyond the set");

  a_absent_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_PRESENT) |->
      !out_found && (out_position == out_set_count))
    else $error("absent key must report the entry count");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(out_set_count) <= CMP_W'(CAPACITY)))
    else $error("entry count exceeds capacity");

endmodule

bind sorted_unique_set_table_core sust_chk u_sust_chk (.*);
